[sv/cls_pkg.sv]
// Shared types and constants for the compacting list store.
package cls_pkg;

   localparam int POS_W   = 8;
   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_GET    = 2'd2,
      ACT_SET    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_REMOVE,
      CELL_SET
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        rd_en;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

[sv/cls_cell.sv]
// One entry cell of the list: holds a word, shifts down on remove, drives its read leaf.
module cls_cell #(
   parameter int INDEX      = 0,
   parameter int CMPW       = 9,
   parameter int WORD_WIDTH = 32
) (
   input  logic                   clock,
   input  cls_pkg::cell_ctl_type  ctl,
   input  logic [CMPW-1:0]        sel_pos,
   input  logic [CMPW-1:0]        count,
   input  logic [WORD_WIDTH-1:0]  data,
   input  logic [WORD_WIDTH-1:0]  upper,
   output logic [WORD_WIDTH-1:0]  word,
   output logic [WORD_WIDTH-1:0]  leaf
);
   import cls_pkg::*;

   localparam logic [CMPW-1:0] IDX  = CMPW'(INDEX);
   localparam logic [CMPW-1:0] IDX1 = CMPW'(INDEX + 1);

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      unique case (ctl.op)
         CELL_HOLD:   word_in = word_ff;
         CELL_APPEND: if (IDX == count) word_in = data;
         CELL_REMOVE: if (IDX >= sel_pos && IDX1 < count) word_in = upper;
         CELL_SET:    if (IDX == sel_pos) word_in = data;
         default:     word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   // drive the leaf only for the addressed cell, so the tree can OR everything
   assign leaf = (ctl.rd_en && IDX == sel_pos) ? word_ff : '0;

endmodule

[sv/cls_read_tree.sv]
// Registered OR-reduction tree that collects the one addressed cell word.
module cls_read_tree #(
   parameter int LEAVES     = 256,
   parameter int WORD_WIDTH = 32
) (
   input  logic                  clock,
   input  logic [WORD_WIDTH-1:0] leaf [LEAVES],
   output logic [WORD_WIDTH-1:0] root
);
   import cls_pkg::*;

   logic [WORD_WIDTH-1:0] node_ff [1:LEAVES-1];

   for (genvar k = 1; k < LEAVES; k++) begin : g_node
      if (2 * k >= LEAVES) begin : g_from_leaf
         always_ff @(posedge clock) begin
            node_ff[k] <= leaf[2 * k - LEAVES] | leaf[2 * k + 1 - LEAVES];
         end
      end else begin : g_from_node
         always_ff @(posedge clock) begin
            node_ff[k] <= node_ff[2 * k] | node_ff[2 * k + 1];
         end
      end
   end

   assign root = node_ff[1];

endmodule

[sv/compacting_list_store.sv]
// Compacting list store: top level with control, count, cell chain and read tree.
// Append, remove, set and out-of-range get: one transaction per cycle while not busy, result
// strobed on the cycle after acceptance; remove compacts the whole chain in that cycle.
// In-range get: busy while the registered read tree drains; once every tree level has loaded,
// the root goes through the response register and the result is strobed.
// Reset (synchronous, active high) clears count and control; entries stay undefined
// until written. The receiver cannot stall: each result shows for exactly one cycle.
module compacting_list_store #(
   parameter  int LIST_DEPTH = 256,
   parameter  int WORD_WIDTH = 32,
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_action,
   input  logic [cls_pkg::POS_W-1:0]    req_position,
   input  logic [cls_pkg::VALUE_W-1:0]  req_value_in,
   output logic                         rsp_valid,
   output logic                         rsp_ok,
   output logic [cls_pkg::VALUE_W-1:0]  rsp_value_out,
   output logic [CNT_W-1:0]             rsp_count_out
);
   import cls_pkg::*;

   // compare width: wide enough for both the position field and the count
   localparam int CMPW   = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int LVLS   = $clog2(LIST_DEPTH);
   localparam int LEAVES = 1 << LVLS;
   localparam int RCW    = $clog2(LVLS + 1);

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [RCW-1:0]    rcnt_ff,  rcnt_in;
   logic [CMPW-1:0]   pos_ff,   pos_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff,    rsp_ok_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic               accept;
   action_type         act;
   logic [CMPW-1:0]    pos_ext;
   logic [CMPW-1:0]    cnt_ext;
   logic               in_range;
   logic               not_full;
   logic               read_last;
   logic               get_long;

   cell_ctl_type           ctl;
   cell_op_type            cell_op;
   logic                   cell_rd;
   logic [CMPW-1:0]        bus_pos;
   logic [WORD_WIDTH-1:0]  bus_data;
   logic [WORD_WIDTH-1:0]  cell_word [LIST_DEPTH];
   logic [WORD_WIDTH-1:0]  leaf      [LEAVES];
   logic [WORD_WIDTH-1:0]  root;

   // decode the incoming transaction
   assign accept    = start && !busy;
   assign act       = action_type'(req_action);
   assign pos_ext   = CMPW'(req_position);
   assign cnt_ext   = CMPW'(count_ff);
   assign in_range  = pos_ext < cnt_ext;
   assign not_full  = count_ff < CNT_W'(LIST_DEPTH);
   // the root holds the addressed word once every tree level has been loaded
   assign read_last = (state_ff == ST_READ) && (rcnt_ff == RCW'(LVLS));
   assign get_long  = accept && (act == ACT_GET) && in_range;
   assign bus_data  = WORD_WIDTH'(req_value_in);
   assign ctl       = '{op: cell_op, rd_en: cell_rd};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (get_long)  state_in = ST_READ;
         ST_READ: if (read_last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs: hold off new transactions and steer the cell bus while reading
   always_comb begin
      busy    = 1'b0;
      cell_rd = 1'b0;
      bus_pos = pos_ext;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_READ: begin
            busy    = 1'b1;
            cell_rd = 1'b1;
            bus_pos = pos_ff;
         end
         default: busy = 1'b0;
      endcase
   end

   // cell command and count update; failed actions leave the chain untouched
   always_comb begin
      cell_op  = CELL_HOLD;
      count_in = count_ff;
      if (accept) begin
         unique case (act)
            ACT_APPEND: if (not_full) begin
               cell_op  = CELL_APPEND;
               count_in = count_ff + CNT_W'(1);
            end
            ACT_REMOVE: if (in_range) begin
               cell_op  = CELL_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end
            ACT_SET:    if (in_range) cell_op = CELL_SET;
            ACT_GET:    cell_op = CELL_HOLD;
            default:    cell_op = CELL_HOLD;
         endcase
      end
   end

   // read counter and captured position
   always_comb begin
      rcnt_in = rcnt_ff;
      pos_in  = pos_ff;
      if (accept) begin
         rcnt_in = '0;
         pos_in  = pos_ext;
      end else if (state_ff == ST_READ) begin
         rcnt_in = rcnt_ff + RCW'(1);
      end
   end

   // response: immediate for everything but an in-range get, which waits for the tree
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_value_in = '0;
      rsp_count_in = count_in;
      if (read_last) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b1;
         rsp_value_in = VALUE_W'(root);
         rsp_count_in = count_ff;
      end else if (accept && !get_long) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = (act == ACT_APPEND) ? not_full : in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rcnt_ff      <= rcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
   end

   // chain of entry cells; on remove, cells from the removed position up take the upper neighbour's word
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] upper;
      if (i == LIST_DEPTH - 1) begin : g_top
         assign upper = cell_word[i];
      end else begin : g_mid
         assign upper = cell_word[i + 1];
      end
      cls_cell #(
         .INDEX      (i),
         .CMPW       (CMPW),
         .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .sel_pos (bus_pos),
         .count   (cnt_ext),
         .data    (bus_data),
         .upper   (upper),
         .word    (cell_word[i]),
         .leaf    (leaf[i])
      );
   end

   // pad the tree to a power of two
   for (genvar j = LIST_DEPTH; j < LEAVES; j++) begin : g_pad
      assign leaf[j] = '0;
   end

   cls_read_tree #(
      .LEAVES     (LEAVES),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_tree (
      .clock (clock),
      .leaf  (leaf),
      .root  (root)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_count_out = rsp_count_ff;

endmodule

[verif/compacting_list_store_checker.sv]
// Checker for the compacting list store: shadow list, expected replies, field comparison.
module compacting_list_store_checker #(
   parameter  int LIST_DEPTH = 256,
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [1:0]                  req_action,
   input  logic [cls_pkg::POS_W-1:0]   req_position,
   input  logic [cls_pkg::VALUE_W-1:0] req_value_in,
   input  logic                        rsp_valid,
   input  logic                        rsp_ok,
   input  logic [cls_pkg::VALUE_W-1:0] rsp_value_out,
   input  logic [CNT_W-1:0]            rsp_count_out,
   output int                          mismatch_count,
   output int                          replies_owed
);
   timeunit 1ns;
   timeprecision 1ps;
   import cls_pkg::*;

   typedef struct {
      logic                ok;
      logic [VALUE_W-1:0]  value_out;
      logic [CNT_W-1:0]    count_out;
   } list_reply_type;

   logic [VALUE_W-1:0] shadow_words [LIST_DEPTH];
   logic [CNT_W-1:0]   shadow_count;
   list_reply_type     reply_q [$];

   initial begin
      mismatch_count = 0;
      replies_owed   = 0;
      shadow_count   = '0;
   end

   // Apply one action to the shadow list and return the reply it should give.
   function automatic list_reply_type apply_action(input action_type act,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [VALUE_W-1:0] word);
      list_reply_type r;
      r.ok        = 1'b0;
      r.value_out = '0;
      if (act == ACT_APPEND) begin
         if (shadow_count < LIST_DEPTH) begin
            shadow_words[shadow_count] = word;
            shadow_count = shadow_count + 1'b1;
            r.ok = 1'b1;
         end
      end else if (pos < shadow_count) begin
         r.ok = 1'b1;
         case (act)
            ACT_REMOVE: begin
               for (int i = pos; i < LIST_DEPTH - 1; i++)
                  if (i + 1 < shadow_count) shadow_words[i] = shadow_words[i + 1];
               shadow_count = shadow_count - 1'b1;
            end
            ACT_GET: r.value_out = shadow_words[pos];
            default: shadow_words[pos] = word;
         endcase
      end
      r.count_out = shadow_count;
      return r;
   endfunction

   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         reply_q.delete();
         shadow_count = '0;
      end else begin
         // Match the reply first, so a spurious one never pairs with this edge's request.
         if (rsp_valid) begin
            if (reply_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: reply with no transaction outstanding: ok %b value %h count %0d",
                        $time, rsp_ok, rsp_value_out, rsp_count_out);
            end else begin
               want = reply_q.pop_front();
               if (rsp_ok !== want.ok) begin
                  mismatch_count++;
                  $display("%0t: ok expected %b actual %b", $time, want.ok, rsp_ok);
               end
               if (rsp_value_out !== want.value_out) begin
                  mismatch_count++;
                  $display("%0t: value_out expected %h actual %h",
                           $time, want.value_out, rsp_value_out);
               end
               if (rsp_count_out !== want.count_out) begin
                  mismatch_count++;
                  $display("%0t: count_out expected %0d actual %0d",
                           $time, want.count_out, rsp_count_out);
               end
            end
         end
         if (start && !busy)
            reply_q.push_back(apply_action(action_type'(req_action), req_position,
                                           req_value_in));
      end
      replies_owed = reply_q.size();
   end

endmodule

[verif/compacting_list_store_tb.sv]
// Testbench top for the compacting list store: clock, reset, stimulus and verdict.
module compacting_list_store_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cls_pkg::*;

   localparam int LIST_DEPTH = 256;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   // Shape of the random traffic: grow the list, churn it, or empty it.
   typedef enum {
      TRAFFIC_FILL,
      TRAFFIC_CHURN,
      TRAFFIC_DRAIN
   } traffic_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 start        = 1'b0;
   logic [1:0]           req_action   = ACT_APPEND;
   logic [POS_W-1:0]     req_position = '0;
   logic [VALUE_W-1:0]   req_value_in = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic                 rsp_ok;
   logic [VALUE_W-1:0]   rsp_value_out;
   logic [CNT_W-1:0]     rsp_count_out;

   int mismatch_count;
   int replies_owed;
   int idle_pct = 0;    // chance, in percent, that the sender idles a cycle
   int list_len = 0;    // length of the list as the stimulus side sees it

   compacting_list_store #(
      .LIST_DEPTH(LIST_DEPTH),
      .WORD_WIDTH(VALUE_W)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_position (req_position),
      .req_value_in (req_value_in),
      .rsp_valid    (rsp_valid),
      .rsp_ok       (rsp_ok),
      .rsp_value_out(rsp_value_out),
      .rsp_count_out(rsp_count_out)
   );

   compacting_list_store_checker #(
      .LIST_DEPTH(LIST_DEPTH)
   ) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_position  (req_position),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ok        (rsp_ok),
      .rsp_value_out (rsp_value_out),
      .rsp_count_out (rsp_count_out),
      .mismatch_count(mismatch_count),
      .replies_owed  (replies_owed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Present one transaction and hold it until the block takes it. Idle cycles
   // go in front, so gaps land after every kind of action, long gets included.
   task automatic send_action(input action_type act, input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] word);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_action   <= act;
      req_position <= pos;
      req_value_in <= word;
      // Accepted at the first edge that sees busy low; start stays high after it.
      do @(posedge clock); while (busy);
      // Track the length only to steer positions into range.
      if (act == ACT_APPEND) begin
         if (list_len < LIST_DEPTH) list_len++;
      end else if (act == ACT_REMOVE && pos < list_len) begin
         list_len--;
      end
   endtask

   function automatic action_type pick_action(input traffic_type kind);
      int roll;
      int w_append;
      int w_remove;
      roll = $urandom_range(0, 99);
      case (kind)
         TRAFFIC_FILL:  begin w_append = 80; w_remove = 3;  end
         TRAFFIC_DRAIN: begin w_append = 3;  w_remove = 75; end
         default:       begin w_append = 30; w_remove = 30; end
      endcase
      if (roll < w_append) return ACT_APPEND;
      if (roll < w_append + w_remove) return ACT_REMOVE;
      if (roll < w_append + w_remove + (100 - w_append - w_remove) / 2) return ACT_GET;
      return ACT_SET;
   endfunction

   // One random transaction; positions mostly fall inside the list, the rest anywhere.
   task automatic send_random(input traffic_type kind);
      action_type       act;
      logic [POS_W-1:0] pos;
      act = pick_action(kind);
      if (list_len > 0 && $urandom_range(0, 99) < 80)
         pos = POS_W'($urandom_range(0, list_len - 1));
      else
         pos = POS_W'($urandom_range(0, 255));
      send_action(act, pos, $urandom);
   endtask

   task automatic send_burst(input traffic_type kind, input int n);
      repeat (n) send_random(kind);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every action on an empty list, extreme words, shifting on remove,
      // reads beyond the count (stale cell included), append ignoring its position.
      send_action(ACT_GET,    8'd0,   32'h0000_0000);
      send_action(ACT_REMOVE, 8'd0,   32'h0000_0000);
      send_action(ACT_SET,    8'd255, 32'hFFFF_FFFF);
      send_action(ACT_APPEND, 8'd0,   32'h0000_0000);
      send_action(ACT_APPEND, 8'd0,   32'hFFFF_FFFF);
      send_action(ACT_APPEND, 8'd0,   32'hA5A5_A5A5);
      send_action(ACT_GET,    8'd0,   32'h0000_0000);
      send_action(ACT_GET,    8'd1,   32'h0000_0000);
      send_action(ACT_GET,    8'd3,   32'h0000_0000);
      send_action(ACT_GET,    8'd255, 32'hFFFF_FFFF);
      send_action(ACT_SET,    8'd1,   32'h1234_5678);
      send_action(ACT_GET,    8'd1,   32'h0000_0000);
      send_action(ACT_REMOVE, 8'd0,   32'h0000_0000);
      send_action(ACT_GET,    8'd0,   32'h0000_0000);
      send_action(ACT_REMOVE, 8'd1,   32'h0000_0000);
      send_action(ACT_GET,    8'd1,   32'h0000_0000);
      send_action(ACT_SET,    8'd1,   32'hDEAD_BEEF);
      send_action(ACT_REMOVE, 8'd5,   32'h0000_0000);
      send_action(ACT_APPEND, 8'd255, 32'h5A5A_5A5A);
      send_action(ACT_GET,    8'd1,   32'h0000_0000);
      send_action(ACT_REMOVE, 8'd0,   32'h0000_0000);
      send_action(ACT_REMOVE, 8'd0,   32'h0000_0000);

      // Back to back: fill to capacity, knock on the full list, then churn.
      idle_pct = 0;
      while (list_len < LIST_DEPTH) send_random(TRAFFIC_FILL);
      send_burst(TRAFFIC_FILL, 10);
      send_burst(TRAFFIC_CHURN, 30);

      // Sparse sender: churn, then drain to empty and poke the empty list.
      idle_pct = 83;
      send_burst(TRAFFIC_CHURN, 30);
      while (list_len > 0) send_random(TRAFFIC_DRAIN);
      send_burst(TRAFFIC_DRAIN, 10);

      // Light idling: grow again and churn.
      idle_pct = 22;
      send_burst(TRAFFIC_FILL, 40);
      send_burst(TRAFFIC_CHURN, 20);

      start <= 1'b0;
      // Let the checker register the last transaction, then wait for its reply.
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
sv/cls_pkg.sv
sv/cls_cell.sv
sv/cls_read_tree.sv
sv/compacting_list_store.sv
verif/compacting_list_store_checker.sv
verif/compacting_list_store_tb.sv
